FILE: src/tcw_pkg.sv
package tcw_pkg;

   // Field widths of the request and response beats
   localparam int ACTION_W = 2;
   localparam int CHAR_W   = 8;
   localparam int ATTR_W   = 8;
   localparam int COL_IN_W = 7;
   localparam int ROW_IN_W = 5;
   localparam int CURSOR_W = 11;
   localparam int CELL_W   = CHAR_W + ATTR_W;

   // Action codes
   localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

   // Character codes
   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
   localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;

   // Register file: byte address 4*i, index taken from paddr[2]
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam logic REG_DEFAULT_ATTR = 1'b0;
   localparam logic [ATTR_W-1:0] DEFAULT_ATTR_RESET = 8'd15;

endpackage

FILE: src/tcw_if.sv
// Request channel: one console action per beat
interface tcw_req_if import tcw_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [CHAR_W-1:0]   character;
   logic [ATTR_W-1:0]   attribute;
   logic                at_position;
   logic [COL_IN_W-1:0] col;
   logic [ROW_IN_W-1:0] row;

   modport source (output valid, action, character, attribute, at_position, col, row,
                   input ready);
   modport sink   (input valid, action, character, attribute, at_position, col, row,
                   output ready);
endinterface

// Response channel: cursor and read cell per beat
interface tcw_rsp_if import tcw_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CURSOR_W-1:0] cursor;
   logic [CHAR_W-1:0]   cell_char;
   logic [ATTR_W-1:0]   cell_attr;

   modport source (output valid, cursor, cell_char, cell_attr, input ready);
   modport sink   (input valid, cursor, cell_char, cell_attr, output ready);
endinterface

FILE: src/text_console_writer_unit.sv
// Text console writer: a COLS x ROWS grid of character cells plus a cursor.
// req_chan carries one action per beat (put, clear, read); rsp_chan returns
// exactly one beat per action with the cursor after the action and, for a
// read, the cell contents. csr_* is an APB-style port holding default_attr.
// The block takes one action at a time: req_chan.ready is high only while
// the sequencer is idle. Put and read cell addresses and the cursor index come
// from one shared row*COLS+col multiply-add unit.
// Steps from the accepting edge to rsp_chan.valid:
//   put: address, write, cursor; read: address, read, cursor;
//   unused action code: cursor only; clear: one cell written per cycle,
//   then cursor; put that scrolls: write, read and write of each moved
//   cell through the single memory port, then the bottom row, then cursor.
// After rsp_chan takes the beat, req_chan.ready returns in the next cycle,
// so actions never overlap: a new one is taken only after the last response.
// Reset: the cell memory is swept to zero, one cell per cycle;
// req_chan.ready stays low meanwhile, the register port works throughout.
// A stalled rsp_chan holds the response beat and the block takes no new
// action until it is taken.
module text_console_writer_unit import tcw_pkg::*; #(
   parameter int COLS = 80,
   parameter int ROWS = 25
) (
   input  logic                  clock,
   input  logic                  reset,
   tcw_req_if.sink               req_chan,
   tcw_rsp_if.source             rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int NCELLS = COLS * ROWS;
   localparam int ADDR_W = $clog2(NCELLS);
   localparam int COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int ROW_W  = $clog2(ROWS + 1);

   typedef enum logic [10:0] {
      ST_INIT     = 11'b00000000001,
      ST_IDLE     = 11'b00000000010,
      ST_ADDR     = 11'b00000000100,
      ST_PUT      = 11'b00000001000,
      ST_READ     = 11'b00000010000,
      ST_CURS     = 11'b00000100000,
      ST_RESP     = 11'b00001000000,
      ST_CLEAR    = 11'b00010000000,
      ST_SCR_RD   = 11'b00100000000,
      ST_SCR_WR   = 11'b01000000000,
      ST_SCR_ZERO = 11'b10000000000
   } state_type;

   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   ptr_ff, ptr_in;
   logic [ROW_W-1:0]    crow_ff, crow_in;
   logic [COL_W-1:0]    ccol_ff, ccol_in;
   logic [ATTR_W-1:0]   default_attr_ff, default_attr_in;

   logic [ACTION_W-1:0] act_ff, act_in;
   logic [CHAR_W-1:0]   char_ff, char_in;
   logic [ATTR_W-1:0]   attr_ff, attr_in;
   logic [ROW_W-1:0]    pos_row_ff, pos_row_in;
   logic [COL_W-1:0]    pos_col_ff, pos_col_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [CURSOR_W-1:0] rsp_cursor_ff, rsp_cursor_in;
   logic [CHAR_W-1:0]   rsp_char_ff, rsp_char_in;
   logic [ATTR_W-1:0]   rsp_attr_ff, rsp_attr_in;

   logic [CELL_W-1:0]   cell_mem [NCELLS];
   logic [CELL_W-1:0]   mem_rdata_ff;
   logic [ADDR_W-1:0]   mem_addr;
   logic                mem_we;
   logic [CELL_W-1:0]   mem_wdata;

   logic [ROW_W-1:0]    mul_row;
   logic [COL_W-1:0]    mul_col;
   logic [ADDR_W-1:0]   mul_res;

   logic [8:0]          col_wide, col_sat;
   logic [7:0]          row_wide, row_sat;
   logic                is_newline, last_col, wrap;
   logic [ROW_W-1:0]    next_row;
   logic [COL_W-1:0]    next_col;
   logic                csr_write;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[2] == REG_DEFAULT_ATTR);
   assign default_attr_in = csr_write ? csr_pwdata[ATTR_W-1:0] : default_attr_ff;
   assign csr_prdata = (csr_paddr[2] == REG_DEFAULT_ATTR) ?
                       CSR_DATA_W'(default_attr_ff) : '0;

   // Handshakes and response payload
   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = (state_ff == ST_RESP);
   assign rsp_chan.cursor    = rsp_cursor_ff;
   assign rsp_chan.cell_char = rsp_char_ff;
   assign rsp_chan.cell_attr = rsp_attr_ff;

   // Saturate an explicit position into the grid
   assign col_wide = {2'b00, req_chan.col};
   assign col_sat  = (col_wide >= 9'(COLS)) ? 9'(COLS - 1) : col_wide;
   assign row_wide = {3'b000, req_chan.row};
   assign row_sat  = (row_wide >= 8'(ROWS)) ? 8'(ROWS - 1) : row_wide;

   // Shared multiply-add unit: cell index = row*COLS + col
   assign mul_row = (state_ff == ST_CURS) ? crow_ff : pos_row_ff;
   assign mul_col = (state_ff == ST_CURS) ? ccol_ff : pos_col_ff;
   assign mul_res = ADDR_W'(ADDR_W'(mul_row) * ADDR_W'(COLS)) + ADDR_W'(mul_col);

   // Cursor step after a put
   assign is_newline = (char_ff == NEWLINE_CODE);
   assign last_col   = (pos_col_ff == COL_W'(COLS - 1));
   assign wrap       = is_newline || last_col;
   assign next_row   = wrap ? pos_row_ff + ROW_W'(1) : pos_row_ff;
   assign next_col   = wrap ? '0 : pos_col_ff + COL_W'(1);

   // Memory port steering
   always_comb begin
      mem_we    = 1'b0;
      mem_addr  = addr_ff;
      mem_wdata = '0;
      case (state_ff)
         ST_INIT, ST_SCR_ZERO: begin
            mem_we   = 1'b1;
            mem_addr = ptr_ff;
         end
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = ptr_ff;
            mem_wdata = {default_attr_ff, SPACE_CODE};
         end
         ST_PUT: begin
            mem_we    = !is_newline;
            mem_wdata = {attr_ff, char_ff};
         end
         ST_SCR_RD: begin
            mem_addr = ptr_ff + ADDR_W'(COLS);
         end
         ST_SCR_WR: begin
            mem_we    = 1'b1;
            mem_addr  = ptr_ff;
            mem_wdata = mem_rdata_ff;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // Cell memory, single port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[mem_addr] <= mem_wdata;
      end
      mem_rdata_ff <= cell_mem[mem_addr];
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      crow_in       = crow_ff;
      ccol_in       = ccol_ff;
      act_in        = act_ff;
      char_in       = char_ff;
      attr_in       = attr_ff;
      pos_row_in    = pos_row_ff;
      pos_col_in    = pos_col_ff;
      addr_in       = addr_ff;
      rsp_cursor_in = rsp_cursor_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_attr_in   = rsp_attr_ff;
      case (state_ff)
         ST_INIT: begin
            ptr_in = ptr_ff + ADDR_W'(1);
            if (ptr_ff == ADDR_W'(NCELLS - 1)) begin
               ptr_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_chan.valid) begin
               act_in  = req_chan.action;
               char_in = req_chan.character;
               attr_in = (req_chan.attribute == '0) ? default_attr_ff : req_chan.attribute;
               if (req_chan.at_position || (req_chan.action == ACT_READ)) begin
                  pos_row_in = ROW_W'(row_sat);
                  pos_col_in = COL_W'(col_sat);
               end else begin
                  pos_row_in = crow_ff;
                  pos_col_in = ccol_ff;
               end
               case (req_chan.action)
                  ACT_PUT, ACT_READ: begin
                     state_in = ST_ADDR;
                  end
                  ACT_CLEAR: begin
                     ptr_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_CURS;
                  end
               endcase
            end
         end
         ST_ADDR: begin
            addr_in  = mul_res;
            state_in = (act_ff == ACT_READ) ? ST_READ : ST_PUT;
         end
         ST_PUT: begin
            if (next_row == ROW_W'(ROWS)) begin
               crow_in  = ROW_W'(ROWS - 1);
               ccol_in  = '0;
               ptr_in   = '0;
               state_in = ST_SCR_RD;
            end else begin
               crow_in  = next_row;
               ccol_in  = next_col;
               state_in = ST_CURS;
            end
         end
         ST_READ: begin
            state_in = ST_CURS;
         end
         ST_CURS: begin
            rsp_cursor_in = CURSOR_W'(mul_res);
            if (act_ff == ACT_READ) begin
               rsp_char_in = mem_rdata_ff[CHAR_W-1:0];
               rsp_attr_in = mem_rdata_ff[CELL_W-1:CHAR_W];
            end else begin
               rsp_char_in = '0;
               rsp_attr_in = '0;
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            ptr_in = ptr_ff + ADDR_W'(1);
            if (ptr_ff == ADDR_W'(NCELLS - 1)) begin
               crow_in  = '0;
               ccol_in  = '0;
               state_in = ST_CURS;
            end
         end
         ST_SCR_RD: begin
            state_in = ST_SCR_WR;
         end
         ST_SCR_WR: begin
            ptr_in = ptr_ff + ADDR_W'(1);
            // last moved cell: go on to blank the bottom row
            state_in = (ptr_ff == ADDR_W'(NCELLS - COLS - 1)) ? ST_SCR_ZERO : ST_SCR_RD;
         end
         ST_SCR_ZERO: begin
            ptr_in = ptr_ff + ADDR_W'(1);
            if (ptr_ff == ADDR_W'(NCELLS - 1)) begin
               state_in = ST_CURS;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_INIT;
         ptr_ff          <= '0;
         crow_ff         <= '0;
         ccol_ff         <= '0;
         default_attr_ff <= DEFAULT_ATTR_RESET;
      end else begin
         state_ff        <= state_in;
         ptr_ff          <= ptr_in;
         crow_ff         <= crow_in;
         ccol_ff         <= ccol_in;
         default_attr_ff <= default_attr_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      char_ff       <= char_in;
      attr_ff       <= attr_in;
      pos_row_ff    <= pos_row_in;
      pos_col_ff    <= pos_col_in;
      addr_ff       <= addr_in;
      rsp_cursor_ff <= rsp_cursor_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_attr_ff   <= rsp_attr_in;
   end

   // Checks
   a_cursor_in_grid: assert property (@(posedge clock) disable iff (reset)
      (crow_ff < ROW_W'(ROWS)) && ({1'b0, ccol_ff} < (COL_W + 1)'(COLS)))
      else $error("cursor outside the grid");

   a_scroll_ptr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCR_RD || state_ff == ST_SCR_WR) |->
      (ptr_ff < ADDR_W'(NCELLS - COLS)))
      else $error("scroll copy pointer past the moved rows");

   a_quiet_cells: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (act_ff != ACT_READ)) |->
      (rsp_char_ff == '0 && rsp_attr_ff == '0))
      else $error("cell fields set on a non-read response");

   a_ready_after_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready) |=> req_chan.ready)
      else $error("not ready after response beat");

   a_scroll_cursor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUT && state_in == ST_SCR_RD) |=>
      (crow_ff == ROW_W'(ROWS - 1) && ccol_ff == '0))
      else $error("cursor not on bottom row start after scroll");

endmodule
